### rtl/cscan_pkg.sv
// ============================================================================
// cscan_pkg
// Shared widths, register indexes, reset values and control structs for the
// C-SCAN disk scheduler.
// ============================================================================
package cscan_pkg;

    localparam int TRK_W            = 16;
    localparam int SEEK_W           = 18;
    localparam int CFG_IDX_W        = 2;
    localparam int MAX_REQUESTS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LAST_TRACK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_POSITION = 2'd1;

    localparam logic [TRK_W-1:0] LAST_TRACK_RST = 16'd199;
    localparam logic [TRK_W-1:0] HEAD_RST       = 16'd0;

    typedef struct packed {
        logic start;
        logic sample_vld;
        logic phase_b;
        logic cur_vld;
    } t_scan_ctl;

    typedef struct packed {
        logic             found;
        logic             single;
        logic [TRK_W-1:0] best_trk;
    } t_scan_stat;

endpackage

### rtl/cscan_disk_scheduler_top.sv
// An accepted request is stored while the store has room; a marked request
// starts the sweep. Each result of a batch follows a scan of the stored
// requests and is then loaded into the output register. One compare and select
// unit reads the store one entry per cycle; no new request is taken until the
// last result is loaded. Synchronous active-low reset clears the batch, the
// output valid and the registers to their defaults.
// ============================================================================
// cscan_disk_scheduler_top
// C-SCAN disk scheduler: collects a batch of track requests and emits the
// circular elevator service order with the running seek distance.
// ============================================================================
module cscan_disk_scheduler_top #(
    parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cscan_pkg::TRK_W-1:0]     i_request_track,
    input  logic                            i_last_request,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cscan_pkg::TRK_W-1:0]     o_service_track,
    output logic [cscan_pkg::SEEK_W-1:0]    o_seek_so_far,
    output logic                            o_last_in_run,
    output logic                            o_requests_dropped,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cscan_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cscan_pkg::TRK_W-1:0]     i_cfg_data
);

    localparam int IDXW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNTW = $clog2(MAX_REQUESTS + 1);
    localparam int TW   = cscan_pkg::TRK_W;
    localparam int SW   = cscan_pkg::SEEK_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [1:0] K_REQ  = 2'd0;
    localparam logic [1:0] K_LAST = 2'd1;
    localparam logic [1:0] K_ZERO = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [1:0]      r_kind, n_kind;
    logic            r_phase_b, n_phase_b;
    logic            r_zero_done, n_zero_done;
    logic            r_cur_vld, n_cur_vld;
    logic [CNTW-1:0] r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CNTW-1:0] r_rd_idx, n_rd_idx;
    logic            r_smp_vld;
    logic [IDXW-1:0] r_smp_idx;
    logic [TW-1:0]   r_last_track;
    logic [TW-1:0]   r_head;
    logic            r_out_vld, n_out_vld;

    logic [TW-1:0]   r_cur_trk, n_cur_trk;
    logic [IDXW-1:0] r_cur_idx, n_cur_idx;
    logic [SW-1:0]   r_seek, n_seek;
    logic [TW-1:0]   r_pos, n_pos;
    logic [TW-1:0]   r_out_trk;
    logic [SW-1:0]   r_out_seek;
    logic            r_out_last;
    logic            r_out_drop;

    logic                  in_acc;
    logic                  store_we;
    logic                  out_free;
    logic                  out_load;
    logic                  issue;
    logic                  scan_done;
    logic [TW-1:0]         tgt;
    logic [TW-1:0]         diff;
    logic [SW-1:0]         sum;
    logic                  emit_last;
    logic [TW-1:0]         rd_data;
    logic [IDXW-1:0]       best_idx;
    cscan_pkg::t_scan_ctl  scan_ctl;
    cscan_pkg::t_scan_stat scan_stat;

    cscan_store #(
        .DEPTH (MAX_REQUESTS),
        .IDXW  (IDXW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[IDXW-1:0]),
        .i_wdata (i_request_track),
        .i_raddr (r_rd_idx[IDXW-1:0]),
        .o_rdata (rd_data)
    );

    cscan_scan #(
        .IDXW (IDXW),
        .CNTW (CNTW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_data     (rd_data),
        .i_idx      (r_smp_idx),
        .i_head     (r_head),
        .i_cur_trk  (r_cur_trk),
        .i_cur_idx  (r_cur_idx),
        .o_stat     (scan_stat),
        .o_best_idx (best_idx)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc = i_in_valid && !o_in_stall;
    assign store_we = in_acc && (r_count < CNTW'(MAX_REQUESTS));
    assign issue = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign scan_done = (r_rd_idx == r_count) && !r_smp_vld;
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        case (r_kind)
            K_REQ:   tgt = scan_stat.best_trk;
            K_LAST:  tgt = r_last_track;
            default: tgt = '0;
        endcase
        diff = (tgt > r_pos) ? (tgt - r_pos) : (r_pos - tgt);
        sum  = r_seek + SW'(diff);
        case (r_kind)
            K_ZERO:  emit_last = !scan_stat.found;
            K_REQ:   emit_last = r_phase_b && scan_stat.single;
            default: emit_last = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_phase_b   = r_phase_b;
        n_zero_done = r_zero_done;
        n_cur_vld   = r_cur_vld;
        n_cur_trk   = r_cur_trk;
        n_cur_idx   = r_cur_idx;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_rd_idx    = r_rd_idx;
        n_seek      = r_seek;
        n_pos       = r_pos;
        out_load    = 1'b0;
        scan_ctl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (store_we) begin
                        n_count = r_count + CNTW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_request) begin
                        n_state        = S_SCAN;
                        scan_ctl.start = 1'b1;
                        n_rd_idx       = '0;
                        n_phase_b      = 1'b0;
                        n_cur_vld      = 1'b0;
                        n_zero_done    = 1'b0;
                        n_seek         = '0;
                        n_pos          = r_head;
                    end
                end
            end
            S_SCAN: begin
                if (!scan_done) begin
                    if (issue) begin
                        n_rd_idx = r_rd_idx + CNTW'(1);
                    end
                end else if (!r_phase_b) begin
                    n_kind  = scan_stat.found ? K_REQ : K_LAST;
                    n_state = S_EMIT;
                end else if (!r_zero_done) begin
                    n_kind      = K_ZERO;
                    n_zero_done = 1'b1;
                    n_state     = S_EMIT;
                end else if (scan_stat.found) begin
                    n_kind  = K_REQ;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_seek   = sum;
                    n_pos    = tgt;
                    case (r_kind)
                        K_REQ: begin
                            if (emit_last) begin
                                n_state = S_IDLE;
                                n_count = '0;
                                n_ovf   = 1'b0;
                            end else begin
                                n_cur_vld      = 1'b1;
                                n_cur_trk      = scan_stat.best_trk;
                                n_cur_idx      = best_idx;
                                n_rd_idx       = '0;
                                scan_ctl.start = 1'b1;
                                n_state        = S_SCAN;
                            end
                        end
                        K_LAST: begin
                            n_phase_b      = 1'b1;
                            n_cur_vld      = 1'b0;
                            n_rd_idx       = '0;
                            scan_ctl.start = 1'b1;
                            n_state        = S_SCAN;
                        end
                        default: begin
                            if (scan_stat.found) begin
                                n_kind = K_REQ;
                            end else begin
                                n_state = S_IDLE;
                                n_count = '0;
                                n_ovf   = 1'b0;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        scan_ctl.sample_vld = r_smp_vld;
        scan_ctl.phase_b    = r_phase_b;
        scan_ctl.cur_vld    = r_cur_vld;
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_kind       <= K_REQ;
            r_phase_b    <= 1'b0;
            r_zero_done  <= 1'b0;
            r_cur_vld    <= 1'b0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_rd_idx     <= '0;
            r_smp_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_last_track <= cscan_pkg::LAST_TRACK_RST;
            r_head       <= cscan_pkg::HEAD_RST;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_phase_b   <= n_phase_b;
            r_zero_done <= n_zero_done;
            r_cur_vld   <= n_cur_vld;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_rd_idx    <= n_rd_idx;
            r_smp_vld   <= issue;
            r_out_vld   <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cscan_pkg::CFG_LAST_TRACK:    r_last_track <= i_cfg_data;
                    cscan_pkg::CFG_HEAD_POSITION: r_head       <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp_idx <= r_rd_idx[IDXW-1:0];
        r_cur_trk <= n_cur_trk;
        r_cur_idx <= n_cur_idx;
        r_seek    <= n_seek;
        r_pos     <= n_pos;
        if (out_load) begin
            r_out_trk  <= tgt;
            r_out_seek <= sum;
            r_out_last <= emit_last;
            r_out_drop <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_service_track    = r_out_trk;
    assign o_seek_so_far      = r_out_seek;
    assign o_last_in_run      = r_out_last;
    assign o_requests_dropped = r_out_drop;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_REQUESTS))
        else $error("request count beyond store depth");

    a_req_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && (r_kind == K_REQ) |-> scan_stat.found)
        else $error("request emitted without a selected entry");

    a_seek_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (sum >= r_seek))
        else $error("seek distance wrapped");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && emit_last |=> (r_state == S_IDLE) && (r_count == '0))
        else $error("batch not closed after final result");
`endif

endmodule

### rtl/cscan_store.sv
// ============================================================================
// cscan_store
// Request store: one write port, one read port with registered read data.
// ============================================================================
module cscan_store #(
    parameter int DEPTH = cscan_pkg::MAX_REQUESTS_DEF,
    parameter int IDXW  = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [IDXW-1:0]             i_waddr,
    input  logic [cscan_pkg::TRK_W-1:0] i_wdata,
    input  logic [IDXW-1:0]             i_raddr,
    output logic [cscan_pkg::TRK_W-1:0] o_rdata
);

    logic [cscan_pkg::TRK_W-1:0] r_mem [DEPTH];
    logic [cscan_pkg::TRK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cscan_scan.sv
// ============================================================================
// cscan_scan
// Shared compare and select unit: walks the store one entry a cycle and keeps
// the smallest (track, index) key above the cursor inside the current sweep.
// ============================================================================
module cscan_scan #(
    parameter int IDXW = 5,
    parameter int CNTW = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cscan_pkg::t_scan_ctl        i_ctl,
    input  logic [cscan_pkg::TRK_W-1:0] i_data,
    input  logic [IDXW-1:0]             i_idx,
    input  logic [cscan_pkg::TRK_W-1:0] i_head,
    input  logic [cscan_pkg::TRK_W-1:0] i_cur_trk,
    input  logic [IDXW-1:0]             i_cur_idx,
    output cscan_pkg::t_scan_stat       o_stat,
    output logic [IDXW-1:0]             o_best_idx
);

    logic                        r_found;
    logic [CNTW-1:0]             r_cnt;
    logic [cscan_pkg::TRK_W-1:0] r_best_trk;
    logic [IDXW-1:0]             r_best_idx;
    logic                        in_range;
    logic                        after_cur;
    logic                        cand;
    logic                        better;

    always_comb begin
        in_range  = i_ctl.phase_b ? (i_data < i_head) : (i_data > i_head);
        after_cur = !i_ctl.cur_vld || (i_data > i_cur_trk) ||
                    ((i_data == i_cur_trk) && (i_idx > i_cur_idx));
        cand      = i_ctl.sample_vld && in_range && after_cur;
        better    = !r_found || (i_data < r_best_trk);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else if (cand) begin
            r_cnt <= r_cnt + CNTW'(1);
            if (better) begin
                r_found    <= 1'b1;
                r_best_trk <= i_data;
                r_best_idx <= i_idx;
            end
        end
    end

    assign o_stat.found    = r_found;
    assign o_stat.single   = (r_cnt == CNTW'(1));
    assign o_stat.best_trk = r_best_trk;
    assign o_best_idx      = r_best_idx;

endmodule

### bench/cscan_disk_scheduler_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// cscan_disk_scheduler_top_tb
// Self-checking bench for the C-SCAN scheduler. Track batches go in over the
// request channel with bursty timing, results come back under a random stall
// pattern, and a scoreboard class works out the service order with its
// running seek distance and compares every result field against it.
// ============================================================================
module cscan_disk_scheduler_top_tb;

    localparam int TRK_W          = cscan_pkg::TRK_W;
    localparam int SEEK_W         = cscan_pkg::SEEK_W;
    localparam int CFG_IDX_W      = cscan_pkg::CFG_IDX_W;
    localparam int DEPTH          = cscan_pkg::MAX_REQUESTS_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 120;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [TRK_W-1:0]     TRK_MAX     = '1;

    typedef struct packed {
        logic [TRK_W-1:0]  track;
        logic [SEEK_W-1:0] seek;
        logic              last;
        logic              dropped;
    } t_visit;

    class sweep_scoreboard;
        logic [TRK_W-1:0] store[DEPTH];
        int unsigned      stored;
        bit               overflow;
        logic [TRK_W-1:0] last_trk;
        logic [TRK_W-1:0] head;
        t_visit           visits_due[$];
        int               errors;

        function new();
            stored   = 0;
            overflow = 1'b0;
            last_trk = cscan_pkg::LAST_TRACK_RST;
            head     = cscan_pkg::HEAD_RST;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TRK_W-1:0] data);
            case (idx)
                cscan_pkg::CFG_LAST_TRACK:    last_trk = data;
                cscan_pkg::CFG_HEAD_POSITION: head     = data;
                default: ;
            endcase
        endfunction

        function int unsigned span(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void push_visit(int unsigned trk, int unsigned seek, bit last);
            t_visit v;
            v.track    = trk[TRK_W-1:0];
            v.seek     = seek[SEEK_W-1:0];
            v.last     = last;
            v.dropped  = overflow;
            visits_due = {visits_due, v};
        endfunction

        // Store the request; on the marked one, build the whole sweep.
        function void take_request(logic [TRK_W-1:0] trk, logic mark);
            int unsigned keys[DEPTH];
            int unsigned key;
            int unsigned pos;
            int unsigned seek;
            int          n;
            int          i;
            int          j;
            bit          low_side;
            if (stored < DEPTH) begin
                store[stored] = trk;
                stored++;
            end else begin
                overflow = 1'b1;
            end
            if (!mark)
                return;
            // Tracks below the head sort after all tracks above it.
            n = 0;
            for (i = 0; i < stored; i++) begin
                if (store[i] != head) begin
                    key = (store[i] < head) ? (32'h10000 | store[i]) : store[i];
                    j = n;
                    while (j > 0 && keys[j-1] > key) begin
                        keys[j] = keys[j-1];
                        j--;
                    end
                    keys[j] = key;
                    n++;
                end
            end
            pos      = head;
            seek     = 0;
            low_side = 1'b0;
            for (i = 0; i <= n; i++) begin
                if (!low_side && (i == n || keys[i][16])) begin
                    seek += span(last_trk, pos);
                    push_visit(last_trk, seek, 1'b0);
                    seek += last_trk;
                    pos = 0;
                    push_visit(0, seek, i == n);
                    low_side = 1'b1;
                end
                if (i < n) begin
                    seek += span(keys[i][15:0], pos);
                    pos = keys[i][15:0];
                    push_visit(pos, seek, low_side && i == n - 1);
                end
            end
            stored   = 0;
            overflow = 1'b0;
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH %s", $time, what);
            errors++;
        endtask

        task check_visit(t_visit got);
            t_visit want;
            if (visits_due.size() == 0) begin
                report($sformatf("unexpected result track=%0d seek=%0d",
                                 got.track, got.seek));
                return;
            end
            want = visits_due.pop_front();
            if (got.track !== want.track || got.seek !== want.seek ||
                got.last !== want.last || got.dropped !== want.dropped)
                report($sformatf({"got trk=%0d seek=%0d last=%0b drop=%0b, ",
                                  "exp trk=%0d seek=%0d last=%0b drop=%0b"},
                                 got.track, got.seek, got.last, got.dropped,
                                 want.track, want.seek, want.last, want.dropped));
        endtask

        function int pending();
            return visits_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [TRK_W-1:0]      i_request_track;
    logic                  i_last_request;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [TRK_W-1:0]      o_service_track;
    logic [SEEK_W-1:0]     o_seek_so_far;
    logic                  o_last_in_run;
    logic                  o_requests_dropped;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [TRK_W-1:0]      i_cfg_data;

    sweep_scoreboard       sb;
    int                    burst_left;
    bit                    hold_req;
    int                    idle_cycles;
    int                    sent;
    int                    batch;
    int                    batch_size;
    int                    k;
    logic [TRK_W-1:0]      prev_trk;
    logic [TRK_W-1:0]      trk;

    cscan_disk_scheduler_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_request_track    (i_request_track),
        .i_last_request     (i_last_request),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_service_track    (o_service_track),
        .o_seek_so_far      (o_seek_so_far),
        .o_last_in_run      (o_last_in_run),
        .o_requests_dropped (o_requests_dropped),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.take_request(i_request_track, i_last_request);
            if (o_out_valid && !i_out_stall)
                sb.check_visit({o_service_track, o_seek_so_far, o_last_in_run,
                                o_requests_dropped});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall modes, plus a long hold-off on request.
    initial begin : out_stall_gen
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic idle_in(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send_request(logic [TRK_W-1:0] track, logic mark);
        if (burst_left == 0) begin
            idle_in($urandom_range(0, 6));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_request_track <= track;
        i_last_request  <= mark;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and hold until every expected result has been taken.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [TRK_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure();
        logic [TRK_W-1:0] lt;
        logic [TRK_W-1:0] hd;
        lt = sb.last_trk;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0:       lt = 16'd1;
                1:       lt = TRK_MAX;
                2, 3:    lt = TRK_W'($urandom_range(1, 65535));
                default: lt = TRK_W'($urandom_range(100, 2000));
            endcase
            program_reg(cscan_pkg::CFG_LAST_TRACK, lt);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0:       hd = '0;
                1:       hd = TRK_MAX;
                2:       hd = TRK_W'($urandom_range(0, 65535));
                default: hd = TRK_W'($urandom_range(0, lt));
            endcase
            program_reg(cscan_pkg::CFG_HEAD_POSITION, hd);
        end
        if ($urandom_range(0, 4) == 0)
            program_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                        TRK_W'($urandom_range(0, 65535)));
    endtask

    function automatic logic [TRK_W-1:0] pick_track(logic [TRK_W-1:0] prev);
        int unsigned lt;
        lt = sb.last_trk;
        case ($urandom_range(0, 9))
            0, 1:    return sb.head;
            2, 3:    return prev;
            4:       return $urandom_range(0, 1) ? TRK_MAX : '0;
            5:       return TRK_W'($urandom_range(0, 65535));
            6:       return (lt < 65535) ? TRK_W'($urandom_range(lt + 1, 65535))
                                         : TRK_W'($urandom_range(0, 65535));
            default: return TRK_W'($urandom_range(0, lt));
        endcase
    endfunction

    initial begin
        sb              = new();
        burst_left      = 0;
        hold_req        = 1'b0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_request_track = '0;
        i_last_request  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = cscan_pkg::CFG_LAST_TRACK;
        i_cfg_data      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: head at zero, duplicates, request equal to head.
        send_request(16'd50, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd20, 1'b0);
        send_request(16'd20, 1'b0);
        send_request(16'd120, 1'b1);
        settle();

        // Full-size disk with head at the top track: nothing above.
        program_reg(cscan_pkg::CFG_LAST_TRACK, TRK_MAX);
        program_reg(cscan_pkg::CFG_HEAD_POSITION, TRK_MAX);
        send_request(TRK_MAX, 1'b0);
        send_request(16'd1, 1'b0);
        send_request(16'd0, 1'b1);
        settle();

        // Smallest disk, request beyond the last track.
        program_reg(cscan_pkg::CFG_LAST_TRACK, 16'd1);
        program_reg(cscan_pkg::CFG_HEAD_POSITION, 16'd0);
        program_reg(CFG_SPARE_A, 16'h5A5A);
        send_request(TRK_MAX, 1'b0);
        send_request(16'd1, 1'b1);
        settle();

        // Head beyond the last track.
        program_reg(cscan_pkg::CFG_LAST_TRACK, 16'd100);
        program_reg(cscan_pkg::CFG_HEAD_POSITION, 16'd300);
        send_request(16'd50, 1'b0);
        send_request(16'd400, 1'b0);
        send_request(16'd300, 1'b1);
        settle();

        // Lone request on the head: sentinels only.
        program_reg(cscan_pkg::CFG_LAST_TRACK, 16'd1000);
        program_reg(cscan_pkg::CFG_HEAD_POSITION, 16'd500);
        program_reg(CFG_SPARE_B, TRK_MAX);
        send_request(16'd500, 1'b1);
        settle();

        // Head moves mid-batch: the new head decides what is dropped.
        program_reg(cscan_pkg::CFG_LAST_TRACK, 16'd200);
        program_reg(cscan_pkg::CFG_HEAD_POSITION, 16'd10);
        send_request(16'd40, 1'b0);
        send_request(16'd10, 1'b0);
        settle();
        program_reg(cscan_pkg::CFG_HEAD_POSITION, 16'd40);
        send_request(16'd5, 1'b1);
        settle();

        sent  = 0;
        batch = 0;
        while (sent < RANDOM_ITEMS) begin
            if (batch == 0 || (batch != 4 && $urandom_range(0, 2) == 0)) begin
                settle();
                reconfigure();
            end
            if (batch == 1)
                batch_size = DEPTH + 1;
            else if (batch == 4)
                batch_size = DEPTH + 3;
            else if ($urandom_range(0, 15) == 0)
                batch_size = $urandom_range(20, DEPTH + 2);
            else
                batch_size = $urandom_range(1, 6);
            prev_trk = sb.head;
            for (k = 0; k < batch_size; k++) begin
                trk = pick_track(prev_trk);
                // Hold off the receiver so the next batch backs up.
                if (batch == 3 && k == batch_size - 1)
                    hold_req = 1'b1;
                send_request(trk, k == batch_size - 1);
                prev_trk = trk;
            end
            sent += batch_size;
            batch++;
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/cscan_pkg.sv
rtl/cscan_store.sv
rtl/cscan_scan.sv
rtl/cscan_disk_scheduler_top.sv
bench/cscan_disk_scheduler_top_tb.sv
